// ===== design/stbs_pkg.sv =====
// Shared types, constants and control program for the sorted table search core.
`default_nettype none

package stbs_pkg;

  // Table geometry and register reset.
  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam logic [10:0] ENTRY_COUNT_RESET = 11'd1024;

  // Command modes.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Command beat.
  typedef struct packed {
    logic               mode;
    logic [9:0]         write_index;
    logic signed [31:0] write_value;
    logic signed [31:0] search_key;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } result_t;

  // Sequencer step addresses.
  localparam logic [2:0] STEP_WAIT  = 3'd0;
  localparam logic [2:0] STEP_INIT  = 3'd1;
  localparam logic [2:0] STEP_PROBE = 3'd2;
  localparam logic [2:0] STEP_TEST  = 3'd3;
  localparam logic [2:0] STEP_MISS  = 3'd4;
  localparam logic [2:0] STEP_HIT   = 3'd5;

  // Jump condition selects.
  localparam logic [1:0] COND_NONE   = 2'd0;
  localparam logic [1:0] COND_SEARCH = 2'd1;
  localparam logic [1:0] COND_EMPTY  = 2'd2;
  localparam logic [1:0] COND_MATCH  = 2'd3;

  // One control word.
  typedef struct packed {
    logic [1:0] cond;      // jump condition
    logic [2:0] jump;      // target when the condition holds
    logic [2:0] next;      // target otherwise
    logic       idle;      // accepts commands and config
    logic       init;      // load search bounds
    logic       probe;     // read table at the midpoint
    logic       narrow;    // halve the range after a miss
    logic       done;      // issue a result
    logic       hit;       // result is a match
  } ctl_t;

  // Control program store.
  function automatic ctl_t ucode_rom(input logic [2:0] step);
    ctl_t c;
    c = '0;
    unique case (step)
      STEP_WAIT: begin
        c.cond = COND_SEARCH; c.jump = STEP_INIT; c.next = STEP_WAIT; c.idle = 1'b1;
      end
      STEP_INIT: begin
        c.next = STEP_PROBE; c.init = 1'b1;
      end
      STEP_PROBE: begin
        c.cond = COND_EMPTY; c.jump = STEP_MISS; c.next = STEP_TEST; c.probe = 1'b1;
      end
      STEP_TEST: begin
        c.cond = COND_MATCH; c.jump = STEP_HIT; c.next = STEP_PROBE; c.narrow = 1'b1;
      end
      STEP_MISS: begin
        c.next = STEP_WAIT; c.done = 1'b1;
      end
      STEP_HIT: begin
        c.next = STEP_WAIT; c.done = 1'b1; c.hit = 1'b1;
      end
      default: begin
        c.next = STEP_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sorted_table_binary_search_core.sv =====
// Sorted table binary search core: table memory, search datapath and microcoded sequencer.
//
// A command with mode write stores one table entry and gives no result; busy stays low.
// A search command keeps busy high from the INIT step through its last step, MISS when the key
// is absent and HIT when it is found; a full 1024-entry table takes at most 11 probes.
// Each probe costs two sequencer steps, one registered table read at the midpoint
// and one signed compare, and that read/compare pair sets the search time.
// The result appears on the result port marked by done, which is high for exactly one cycle,
// in the cycle after the last step; it cannot be held off, so capture it when done is high. Config
// (entry_count) is taken only while busy is low. Table contents are undefined until written;
// searches must only probe written entries.
`default_nettype none

module sorted_table_binary_search_core
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire cmd_t        cmd,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [10:0] cfg_data,
  output      logic        done,
  output      result_t     result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0] DEPTH_V = (AW+1)'(TABLE_DEPTH);

  // Sequencer state
  logic [2:0]  step;
  ctl_t        ctl;
  logic        cond_true;

  // Datapath registers
  logic [10:0]        entry_count;
  logic signed [31:0] key;
  logic [AW:0]        low;
  logic [AW:0]        hp1;     // high bound plus one
  logic [AW-1:0]      mid;
  logic signed [31:0] rdata;
  logic [31:0]        mem [TABLE_DEPTH];

  logic          accept;
  logic          empty;
  logic          match;
  logic [AW+1:0] mid_sum;
  logic [AW-1:0] mid_next;
  logic [AW:0]   count_sat;

  assign ctl       = ucode_rom(step);
  assign busy      = !ctl.idle;
  assign cfg_ready = ctl.idle;
  assign accept    = start && ctl.idle;

  // Range tests and midpoint
  assign empty    = (low >= hp1);
  assign match    = (rdata == key);
  assign mid_sum  = {1'b0, low} + {1'b0, hp1} - (AW+2)'(1);
  assign mid_next = mid_sum[AW:1];
  assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? DEPTH_V : (AW+1)'(entry_count);

  // Jump condition
  always_comb begin
    unique case (ctl.cond)
      COND_NONE:   cond_true = 1'b0;
      COND_SEARCH: cond_true = accept && (cmd.mode == MODE_SEARCH);
      COND_EMPTY:  cond_true = empty;
      COND_MATCH:  cond_true = match;
      default:     cond_true = 1'b0;
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= cond_true ? ctl.jump : ctl.next;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Table memory: write port on accepted write beats, registered read at the midpoint
  always_ff @(posedge clk) begin
    if (accept && (cmd.mode == MODE_WRITE) && (32'(cmd.write_index) < TABLE_DEPTH)) begin
      mem[AW'(cmd.write_index)] <= cmd.write_value;
    end
    if (ctl.probe) begin
      rdata <= mem[mid_next];
    end
  end

  // Search bounds and key
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= cmd.search_key;
    end
    if (ctl.init) begin
      low <= '0;
      hp1 <= count_sat;
    end
    if (ctl.probe) begin
      mid <= mid_next;
    end
    if (ctl.narrow && !match) begin
      if (rdata > key) begin
        hp1 <= {1'b0, mid};
      end else begin
        low <= {1'b0, mid} + (AW+1)'(1);
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      result.found    <= ctl.hit;
      result.position <= ctl.hit ? 10'(mid) : 10'd0;
    end
  end

  // Checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a search in flight");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.position == 10'd0))
    else $error("miss result carries a nonzero position");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.mode == MODE_SEARCH)) |=> busy)
    else $error("accepted search did not raise busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.mode == MODE_WRITE)) |=> !busy)
    else $error("table write left the core busy");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted table binary search core.
`timescale 1ns / 100ps

module tb_top;
  import stbs_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  // Settle for longer than the longest search, 11 probes on a full table.
  localparam int SEARCH_SETTLE = 30;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  logic        done;
  result_t     result;

  sorted_table_binary_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  // Commands waiting to be driven, and lookups still owed by the core.
  cmd_t    pending_cmds[$];
  result_t expected_results[$];

  // Predicted core state: table updated at each accepted write beat, count at each config write.
  logic signed [31:0] lookup_table [DEPTH];
  logic [10:0]        active_count;

  // Stimulus-side shadow of what was queued, used to pick keys.
  logic signed [31:0] plan_table [DEPTH];
  int                 plan_count;

  int      mismatches = 0;
  int      accepted_items = 0;
  result_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Binary search over the predicted table, signed compare.
  function automatic result_t search_table(input logic signed [31:0] key);
    result_t r;
    int      lo;
    int      hi;
    int      mid;
    int      n;
    r  = '0;
    n  = (active_count > DEPTH) ? DEPTH : int'(active_count);
    lo = 0;
    hi = n - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (lookup_table[mid] == key) begin
        r.found    = 1'b1;
        r.position = mid[9:0];
      end else if (lookup_table[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // Driver: new beat at the falling edge, random gaps outside the steady stretch.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else if (pending_cmds.size() != 0 &&
                 !((accepted_items < 400 || accepted_items >= 800) &&
                   $urandom_range(99) < 7)) begin
      start <= 1'b1;
      cmd   <= pending_cmds[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results, then predict for the accepted command.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                    result.found, result.position));
        end else begin
          want = expected_results.pop_front();
          if (result.found !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", result.found, want.found));
          if (result.position !== want.position)
            report_mismatch($sformatf("position %0d, predicted %0d",
                                      result.position, want.position));
        end
      end
      if (start && !busy) begin
        accepted_items++;
        void'(pending_cmds.pop_front());
        if (cmd.mode == MODE_SEARCH) begin
          expected_results.push_back(search_table(cmd.search_key));
        end else if (cmd.write_index < DEPTH) begin
          lookup_table[cmd.write_index] = cmd.write_value;
        end
      end
    end
  end

  task automatic queue_write(input int idx, input logic signed [31:0] val);
    cmd_t c;
    c.mode        = MODE_WRITE;
    c.write_index = idx[9:0];
    c.write_value = val;
    c.search_key  = $urandom;
    plan_table[idx] = val;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_search(input logic signed [31:0] key);
    cmd_t c;
    c.mode        = MODE_SEARCH;
    c.write_index = $urandom;
    c.write_value = $urandom;
    c.search_key  = key;
    pending_cmds.push_back(c);
  endtask

  // Mostly keys present in the table, some neighbors, some anything.
  task automatic queue_random_search();
    int                 r;
    int                 idx;
    int                 n;
    logic signed [31:0] key;
    n   = (plan_count == 0) ? DEPTH : plan_count;
    r   = $urandom_range(9);
    idx = $urandom_range(n - 1);
    if (r < 6)       key = plan_table[idx];
    else if (r == 6) key = plan_table[idx] + 1;
    else if (r == 7) key = plan_table[idx] - 1;
    else             key = $urandom;
    queue_search(key);
  endtask

  // Ascending values spread over the full signed range, a few repeats.
  task automatic fill_sorted(input int n);
    longint span;
    longint v;
    span = 64'sd4294967296 / n;
    v    = -64'sd2147483648 + longint'($urandom_range(32'(span - 1)));
    for (int i = 0; i < n; i++) begin
      queue_write(i, v[31:0]);
      if ($urandom_range(15) != 0) v += longint'($urandom_range(32'(span - 1)));
    end
  endtask

  // Random overwrites inside the searched range; break the ordering.
  task automatic queue_noise(input int k);
    int n;
    n = (plan_count == 0) ? DEPTH : plan_count;
    repeat (k) queue_write($urandom_range(n - 1), $urandom);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy)
      @(posedge clk);
    repeat (SEARCH_SETTLE) @(posedge clk);
  endtask

  // Register write only once the core has drained.
  task automatic set_entry_count(input logic [10:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    active_count = value;
    plan_count   = (value > DEPTH) ? DEPTH : int'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [10:0] count;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    active_count   = ENTRY_COUNT_RESET;
    plan_count     = DEPTH;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes on a five-entry table, hits and near misses.
    set_entry_count(11'd5);
    queue_write(0, KEY_MIN);
    queue_write(1, -1);
    queue_write(2, 0);
    queue_write(3, 1);
    queue_write(4, KEY_MAX);
    queue_search(KEY_MIN);
    queue_search(-1);
    queue_search(0);
    queue_search(1);
    queue_search(KEY_MAX);
    queue_search(-2);
    queue_search(2);
    queue_search(KEY_MIN + 1);
    queue_search(KEY_MAX - 1);
    // Unsorted table: probe path reported as is.
    queue_write(2, 7);
    queue_search(7);
    queue_search(0);
    // Single entry, then empty range.
    set_entry_count(11'd1);
    queue_search(KEY_MIN);
    queue_search(5);
    set_entry_count(11'd0);
    queue_search(KEY_MIN);

    // Full table, then a count above the depth that saturates.
    set_entry_count(11'd1024);
    fill_sorted(DEPTH);
    repeat (60) queue_random_search();
    set_entry_count(11'd2047);
    queue_noise(3);
    repeat (40) queue_random_search();

    // Mixed sizes; small tables are rebuilt sorted, large ones perturbed.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0:       count = 11'd1;
        1:       count = 11'd2;
        2:       count = 11'($urandom_range(64, 3));
        3:       count = 11'($urandom_range(1023, 65));
        default: count = 11'($urandom_range(2047, 1024));
      endcase
      set_entry_count(count);
      if (count <= 64) fill_sorted(count);
      else queue_noise(4);
      repeat (45) begin
        queue_random_search();
        if ($urandom_range(19) == 0) queue_noise(1);
      end
    end
    set_entry_count(11'd0);
    repeat (8) queue_random_search();

    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
